/* rtl/mepg_pkg.sv */
package mepg_pkg;

    localparam int COORD_BITS = 12;
    localparam int AXIS_BITS  = 8;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int DELTA_BITS = 26;
    localparam int DEC_BITS   = 48;
    localparam int ACC_W      = DEC_BITS + 4;
    localparam int SQ_W       = 2 * AXIS_BITS;
    localparam int MUL_W      = 2 * AXIS_BITS + 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [AXIS_BITS-1:0] SEMI_AXIS_X_RESET = AXIS_BITS'(72);
    localparam logic [AXIS_BITS-1:0] SEMI_AXIS_Y_RESET = AXIS_BITS'(36);

    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_Y = 1'b1;

    localparam logic ITEM_START = 1'b0;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQ_A,
        DP_SQ_B,
        DP_MUL_AB,
        DP_START_ACC,
        DP_DIV,
        DP_TX2,
        DP_TXB,
        DP_YM2,
        DP_YMA,
        DP_ACC_A,
        DP_ACC_B,
        DP_STEP1,
        DP_STEP2,
        DP_EMIT,
        DP_EMIT_NULL
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_MUL_AB,
        ST_START_ACC,
        ST_DIV_S,
        ST_TX2,
        ST_TXB,
        ST_YM2,
        ST_YMA,
        ST_ACC_A,
        ST_ACC_B,
        ST_DIV_R,
        ST_STEP1,
        ST_STEP2,
        ST_EMIT,
        ST_EMIT_NULL
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic active;
        logic region_two;
        logic dx_lt_dy;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/mepg_ctrl.sv */
module mepg_ctrl
    import mepg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        req_stall  = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_SQ_A;
                end
            end
            ST_SQ_A:
            begin
                cmd.op     = DP_SQ_A;
                state_next = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.op = DP_SQ_B;
                if (status.is_start)
                begin
                    state_next = ST_MUL_AB;
                end
                else if (!status.active)
                begin
                    state_next = ST_EMIT_NULL;
                end
                else if (status.region_two)
                begin
                    state_next = ST_STEP2;
                end
                else if (status.dx_lt_dy)
                begin
                    state_next = ST_STEP1;
                end
                else
                begin
                    state_next = ST_TX2;
                end
            end
            ST_MUL_AB:
            begin
                cmd.op     = DP_MUL_AB;
                state_next = ST_START_ACC;
            end
            ST_START_ACC:
            begin
                cmd.op     = DP_START_ACC;
                state_next = ST_DIV_S;
            end
            ST_DIV_S:
            begin
                cmd.op     = DP_DIV;
                state_next = ST_EMIT;
            end
            ST_TX2:
            begin
                cmd.op     = DP_TX2;
                state_next = ST_TXB;
            end
            ST_TXB:
            begin
                cmd.op     = DP_TXB;
                state_next = ST_YM2;
            end
            ST_YM2:
            begin
                cmd.op     = DP_YM2;
                state_next = ST_YMA;
            end
            ST_YMA:
            begin
                cmd.op     = DP_YMA;
                state_next = ST_ACC_A;
            end
            ST_ACC_A:
            begin
                cmd.op     = DP_ACC_A;
                state_next = ST_ACC_B;
            end
            ST_ACC_B:
            begin
                cmd.op     = DP_ACC_B;
                state_next = ST_DIV_R;
            end
            ST_DIV_R:
            begin
                cmd.op     = DP_DIV;
                state_next = ST_STEP2;
            end
            ST_STEP1:
            begin
                cmd.op     = DP_STEP1;
                state_next = ST_EMIT;
            end
            ST_STEP2:
            begin
                cmd.op     = DP_STEP2;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_NULL:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT_NULL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mepg_datapath.sv */
module mepg_datapath
    import mepg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [AXIS_BITS-1:0]        cfg_data,
    input  logic                        op,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        point_valid,
    output logic signed [OUT_BITS-1:0]  right_x,
    output logic signed [OUT_BITS-1:0]  left_x,
    output logic signed [OUT_BITS-1:0]  upper_y,
    output logic signed [OUT_BITS-1:0]  lower_y,
    output logic                        last_point
);

    logic [AXIS_BITS-1:0]  semi_x_reg;
    logic [AXIS_BITS-1:0]  semi_y_reg;
    logic                  active_reg;
    logic                  region_two_reg;
    logic                  res_valid_reg;

    logic                  op_reg;
    logic [COORD_BITS-1:0] cx_in_reg;
    logic [COORD_BITS-1:0] cy_in_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [AXIS_BITS-1:0]  ox_reg;
    logic [AXIS_BITS-1:0]  oy_reg;
    logic [DELTA_BITS-1:0] sdx_reg;
    logic [DELTA_BITS-1:0] sdy_reg;
    logic [DEC_BITS-1:0]   dec_reg;
    logic [SQ_W-1:0]       a2_reg;
    logic [SQ_W-1:0]       b2_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [ACC_W-1:0]      acc_reg;

    logic                  pv_reg;
    logic                  last_reg;
    logic [OUT_BITS-1:0]   rx_reg;
    logic [OUT_BITS-1:0]   lx_reg;
    logic [OUT_BITS-1:0]   uy_reg;
    logic [OUT_BITS-1:0]   ly_reg;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [PROD_W-1:0]     mul_res;

    logic [AXIS_BITS:0]    tx;
    logic [AXIS_BITS-1:0]  ym;
    logic [ACC_W-1:0]      prod_ext;
    logic [ACC_W-1:0]      a2_acc;
    logic [ACC_W-1:0]      b2_acc;
    logic [ACC_W-1:0]      start_q;
    logic [ACC_W-1:0]      div_adj;

    logic [DELTA_BITS-1:0] two_a2;
    logic [DELTA_BITS-1:0] two_b2;
    logic [DELTA_BITS-1:0] sdx_inc;
    logic [DELTA_BITS-1:0] sdy_dec;
    logic [DEC_BITS-1:0]   a2_dec;
    logic [DEC_BITS-1:0]   b2_dec;
    logic [DEC_BITS-1:0]   sdx_inc_dec;
    logic [DEC_BITS-1:0]   sdy_dec_dec;
    logic                  dec_neg;
    logic                  dec_pos;

    logic signed [OUT_BITS-1:0] cx_ext;
    logic signed [OUT_BITS-1:0] cy_ext;
    logic signed [OUT_BITS-1:0] ox_ext;
    logic signed [OUT_BITS-1:0] oy_ext;

    logic                  out_free;

    assign out_free = !res_valid_reg || !res_stall;

    assign status.is_start   = (op_reg == ITEM_START);
    assign status.active     = active_reg;
    assign status.region_two = region_two_reg;
    assign status.dx_lt_dy   = (sdx_reg < sdy_reg);
    assign status.out_free   = out_free;

    // shared multiplier operand select
    assign tx = {ox_reg, 1'b1};
    assign ym = oy_reg - AXIS_BITS'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_SQ_A:
            begin
                mul_a = MUL_W'(semi_x_reg);
                mul_b = MUL_W'(semi_x_reg);
            end
            DP_SQ_B:
            begin
                mul_a = MUL_W'(semi_y_reg);
                mul_b = MUL_W'(semi_y_reg);
            end
            DP_MUL_AB:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(semi_y_reg);
            end
            DP_TX2:
            begin
                mul_a = MUL_W'(tx);
                mul_b = MUL_W'(tx);
            end
            DP_TXB:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(b2_reg);
            end
            DP_YM2:
            begin
                mul_a = MUL_W'(ym);
                mul_b = MUL_W'(ym);
            end
            DP_YMA:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(a2_reg);
            end
            DP_ACC_A:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // accumulator terms, quarter units
    assign prod_ext = ACC_W'(prod_reg);
    assign a2_acc   = ACC_W'(a2_reg);
    assign b2_acc   = ACC_W'(b2_reg);
    assign start_q  = (b2_acc << 2) - (prod_ext << 2) + a2_acc + ACC_W'(2);
    assign div_adj  = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(3) : ACC_W'(0));

    // step increments
    assign two_a2      = DELTA_BITS'({a2_reg, 1'b0});
    assign two_b2      = DELTA_BITS'({b2_reg, 1'b0});
    assign sdx_inc     = sdx_reg + two_b2;
    assign sdy_dec     = sdy_reg - two_a2;
    assign a2_dec      = DEC_BITS'(a2_reg);
    assign b2_dec      = DEC_BITS'(b2_reg);
    assign sdx_inc_dec = DEC_BITS'(sdx_inc);
    assign sdy_dec_dec = DEC_BITS'(sdy_dec);
    assign dec_neg     = dec_reg[DEC_BITS-1];
    assign dec_pos     = !dec_reg[DEC_BITS-1] && (|dec_reg);

    // point set
    assign cx_ext = OUT_BITS'(signed'(cx_reg));
    assign cy_ext = OUT_BITS'(signed'(cy_reg));
    assign ox_ext = signed'(OUT_BITS'(ox_reg));
    assign oy_ext = signed'(OUT_BITS'(oy_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_x_reg     <= SEMI_AXIS_X_RESET;
            semi_y_reg     <= SEMI_AXIS_Y_RESET;
            active_reg     <= 1'b0;
            region_two_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SEMI_AXIS_X: semi_x_reg <= cfg_data;
                    REG_SEMI_AXIS_Y: semi_y_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            case (cmd.op)
                DP_START_ACC:
                begin
                    active_reg     <= 1'b1;
                    region_two_reg <= 1'b0;
                end
                DP_ACC_B:
                begin
                    region_two_reg <= 1'b1;
                end
                DP_EMIT:
                begin
                    if (oy_reg == '0)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.op == DP_EMIT || cmd.op == DP_EMIT_NULL)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg    <= op;
                cx_in_reg <= center_x;
                cy_in_reg <= center_y;
            end
            DP_SQ_A:
            begin
                a2_reg <= mul_res[SQ_W-1:0];
            end
            DP_SQ_B:
            begin
                b2_reg <= mul_res[SQ_W-1:0];
            end
            DP_MUL_AB, DP_TX2, DP_TXB:
            begin
                prod_reg <= mul_res;
            end
            DP_START_ACC:
            begin
                cx_reg  <= cx_in_reg;
                cy_reg  <= cy_in_reg;
                ox_reg  <= '0;
                oy_reg  <= semi_y_reg;
                sdx_reg <= '0;
                sdy_reg <= DELTA_BITS'({prod_reg, 1'b0});
                acc_reg <= start_q;
            end
            DP_DIV:
            begin
                dec_reg <= div_adj[DEC_BITS+1:2];
            end
            DP_YM2:
            begin
                acc_reg  <= prod_ext;
                prod_reg <= mul_res;
            end
            DP_YMA:
            begin
                prod_reg <= mul_res;
            end
            DP_ACC_A:
            begin
                acc_reg  <= acc_reg + (prod_ext << 2);
                prod_reg <= mul_res;
            end
            DP_ACC_B:
            begin
                acc_reg <= acc_reg - (prod_ext << 2) + ACC_W'(2);
            end
            DP_STEP1:
            begin
                ox_reg  <= ox_reg + AXIS_BITS'(1);
                sdx_reg <= sdx_inc;
                if (dec_neg)
                begin
                    dec_reg <= dec_reg + b2_dec + sdx_inc_dec;
                end
                else
                begin
                    oy_reg  <= oy_reg - AXIS_BITS'(1);
                    sdy_reg <= sdy_dec;
                    dec_reg <= dec_reg + b2_dec + sdx_inc_dec - sdy_dec_dec;
                end
            end
            DP_STEP2:
            begin
                oy_reg  <= oy_reg - AXIS_BITS'(1);
                sdy_reg <= sdy_dec;
                if (dec_pos)
                begin
                    dec_reg <= dec_reg + a2_dec - sdy_dec_dec;
                end
                else
                begin
                    ox_reg  <= ox_reg + AXIS_BITS'(1);
                    sdx_reg <= sdx_inc;
                    dec_reg <= dec_reg + a2_dec - sdy_dec_dec + sdx_inc_dec;
                end
            end
            DP_EMIT:
            begin
                pv_reg   <= 1'b1;
                rx_reg   <= cx_ext + ox_ext;
                lx_reg   <= cx_ext - ox_ext;
                uy_reg   <= cy_ext + oy_ext;
                ly_reg   <= cy_ext - oy_ext;
                last_reg <= (oy_reg == '0);
            end
            DP_EMIT_NULL:
            begin
                pv_reg   <= 1'b0;
                rx_reg   <= '0;
                lx_reg   <= '0;
                uy_reg   <= '0;
                ly_reg   <= '0;
                last_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid   = res_valid_reg;
    assign point_valid = pv_reg;
    assign right_x     = signed'(rx_reg);
    assign left_x      = signed'(lx_reg);
    assign upper_y     = signed'(uy_reg);
    assign lower_y     = signed'(ly_reg);
    assign last_point  = last_reg;

endmodule

/* rtl/midpoint_ellipse_point_generator.sv */
// channel   handshake               payload
// request   req_valid / req_stall   op, center_x, center_y
// result    res_valid / res_stall   point_valid, right_x, left_x, upper_y, lower_y, last_point
// config    cfg_we                  cfg_index, cfg_data
//
// one request at a time; req_stall holds from when a request is taken until its result is
// emitted. A start, a step in either region, the region change step (the longest) and a step
// while idle each run their own sequence of controller states around the shared multiplier.
// rst_n clears the controller, the active, region and result valid flags and loads the semi-axes
// a result waits in its register under res_stall; the next request is taken meanwhile
module midpoint_ellipse_point_generator
    import mepg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [AXIS_BITS-1:0]         cfg_data,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         op,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         point_valid,
    output logic signed [OUT_BITS-1:0]   right_x,
    output logic signed [OUT_BITS-1:0]   left_x,
    output logic signed [OUT_BITS-1:0]   upper_y,
    output logic signed [OUT_BITS-1:0]   lower_y,
    output logic                         last_point
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mepg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mepg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .center_x    (center_x),
        .center_y    (center_y),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .point_valid (point_valid),
        .right_x     (right_x),
        .left_x      (left_x),
        .upper_y     (upper_y),
        .lower_y     (lower_y),
        .last_point  (last_point)
    );

endmodule

/* bench/midpoint_ellipse_point_generator_tb.sv */
`timescale 1ns / 100ps

module midpoint_ellipse_point_generator_tb;
    import mepg_pkg::*;

    localparam logic ITEM_STEP     = ~ITEM_START;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   ITEM_TARGET   = 750;

    typedef struct packed {
        logic                       point_valid;
        logic signed [OUT_BITS-1:0] right_x;
        logic signed [OUT_BITS-1:0] left_x;
        logic signed [OUT_BITS-1:0] upper_y;
        logic signed [OUT_BITS-1:0] lower_y;
        logic                       last_point;
    } point_set_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [AXIS_BITS-1:0]         cfg_data = '0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    logic                         op = 1'b0;
    logic signed [COORD_BITS-1:0] center_x = '0;
    logic signed [COORD_BITS-1:0] center_y = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    logic                         point_valid;
    logic signed [OUT_BITS-1:0]   right_x;
    logic signed [OUT_BITS-1:0]   left_x;
    logic signed [OUT_BITS-1:0]   upper_y;
    logic signed [OUT_BITS-1:0]   lower_y;
    logic                         last_point;

    // predictor state
    logic [AXIS_BITS-1:0]         axis_a = SEMI_AXIS_X_RESET;
    logic [AXIS_BITS-1:0]         axis_b = SEMI_AXIS_Y_RESET;
    logic signed [COORD_BITS-1:0] org_x = '0;
    logic signed [COORD_BITS-1:0] org_y = '0;
    logic [AXIS_BITS-1:0]         off_x = '0;
    logic [AXIS_BITS-1:0]         off_y = '0;
    logic [DELTA_BITS-1:0]        dx_term = '0;
    logic [DELTA_BITS-1:0]        dy_term = '0;
    logic signed [DEC_BITS-1:0]   dec_val = '0;
    bit                           in_tail = 1'b0;
    bit                           drawing = 1'b0;

    point_set_t point_queue[$];
    int         mismatch_count = 0;
    int         sent_count = 0;
    int         stall_left = 0;
    bit         hold_pending = 1'b0;
    bit         no_gaps = 1'b0;

    midpoint_ellipse_point_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .center_x    (center_x),
        .center_y    (center_y),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .point_valid (point_valid),
        .right_x     (right_x),
        .left_x      (left_x),
        .upper_y     (upper_y),
        .lower_y     (lower_y),
        .last_point  (last_point)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_500_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_span();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic point_set_t plot_offsets();
        point_set_t ps;
        longint     cx;
        longint     cy;
        cx = org_x;
        cy = org_y;
        ps.point_valid = 1'b1;
        ps.right_x     = OUT_BITS'(cx + longint'(off_x));
        ps.left_x      = OUT_BITS'(cx - longint'(off_x));
        ps.upper_y     = OUT_BITS'(cy + longint'(off_y));
        ps.lower_y     = OUT_BITS'(cy - longint'(off_y));
        ps.last_point  = (off_y == '0);
        if (off_y == '0)
        begin
            drawing = 1'b0;
        end
        return ps;
    endfunction

    function automatic point_set_t advance_ellipse(input logic op_i,
                                                   input logic signed [COORD_BITS-1:0] x_i,
                                                   input logic signed [COORD_BITS-1:0] y_i);
        longint a;
        longint b;
        longint a2;
        longint b2;
        longint q;
        longint p;
        longint tx;
        longint ym;
        a  = axis_a;
        b  = axis_b;
        a2 = a * a;
        b2 = b * b;
        if (op_i == ITEM_START)
        begin
            org_x   = x_i;
            org_y   = y_i;
            off_x   = '0;
            off_y   = axis_b;
            dx_term = '0;
            dy_term = DELTA_BITS'(2 * a2 * b);
            q       = 4 * b2 - 4 * a2 * b + a2 + 2;
            dec_val = DEC_BITS'(q / 4);
            in_tail = 1'b0;
            drawing = 1'b1;
            return plot_offsets();
        end
        if (!drawing)
        begin
            return '0;
        end
        if (!in_tail && dx_term < dy_term)
        begin
            p       = dec_val;
            off_x   = off_x + 1'b1;
            dx_term = dx_term + DELTA_BITS'(2 * b2);
            if (p < 0)
            begin
                dec_val = DEC_BITS'(p + b2 + longint'(dx_term));
            end
            else
            begin
                off_y   = off_y - 1'b1;
                dy_term = dy_term - DELTA_BITS'(2 * a2);
                dec_val = DEC_BITS'(p + b2 + longint'(dx_term) - longint'(dy_term));
            end
        end
        else
        begin
            // region change: fresh decision from the current offsets
            if (!in_tail)
            begin
                tx      = 2 * longint'(off_x) + 1;
                ym      = longint'(off_y) - 1;
                q       = b2 * tx * tx + 4 * a2 * ym * ym - 4 * a2 * b2 + 2;
                dec_val = DEC_BITS'(q / 4);
                in_tail = 1'b1;
            end
            p       = dec_val;
            off_y   = off_y - 1'b1;
            dy_term = dy_term - DELTA_BITS'(2 * a2);
            if (p > 0)
            begin
                dec_val = DEC_BITS'(p + a2 - longint'(dy_term));
            end
            else
            begin
                off_x   = off_x + 1'b1;
                dx_term = dx_term + DELTA_BITS'(2 * b2);
                dec_val = DEC_BITS'(p + a2 - longint'(dy_term) + longint'(dx_term));
            end
        end
        return plot_offsets();
    endfunction

    always @(posedge clk)
    begin : result_monitor
        point_set_t got;
        point_set_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = {point_valid, right_x, left_x, upper_y, lower_y, last_point};
            if (point_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected point set pv=%0b rx=%0d lx=%0d uy=%0d ly=%0d last=%0b",
                         $time, got.point_valid, got.right_x, got.left_x, got.upper_y,
                         got.lower_y, got.last_point);
            end
            else
            begin
                want = point_queue.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: point set mismatch expected pv=%0b rx=%0d lx=%0d uy=%0d ly=%0d last=%0b actual pv=%0b rx=%0d lx=%0d uy=%0d ly=%0d last=%0b",
                             $time, want.point_valid, want.right_x, want.left_x,
                             want.upper_y, want.lower_y, want.last_point,
                             got.point_valid, got.right_x, got.left_x,
                             got.upper_y, got.lower_y, got.last_point);
                end
            end
        end
        // long hold-off counted here
        if (hold_pending)
        begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_left = idle_span();
        end
    end

    task automatic send_request(input logic op_i,
                                input logic signed [COORD_BITS-1:0] x_i,
                                input logic signed [COORD_BITS-1:0] y_i);
        int gap;
        req_valid <= 1'b1;
        op        <= op_i;
        center_x  <= x_i;
        center_y  <= y_i;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        point_queue.push_back(advance_ellipse(op_i, x_i, y_i));
        sent_count++;
        gap = idle_span();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (point_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_axis(input logic [CFG_IDX_W-1:0] idx,
                              input logic [AXIS_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SEMI_AXIS_X)
        begin
            axis_a = value;
        end
        else
        begin
            axis_b = value;
        end
        @(posedge clk);
    endtask

    task automatic set_axes(input logic [AXIS_BITS-1:0] a, input logic [AXIS_BITS-1:0] b);
        wait_idle();
        write_axis(REG_SEMI_AXIS_X, a);
        write_axis(REG_SEMI_AXIS_Y, b);
    endtask

    task automatic trace_ellipse(input logic signed [COORD_BITS-1:0] x_i,
                                 input logic signed [COORD_BITS-1:0] y_i,
                                 input int max_steps);
        int steps;
        steps = 0;
        send_request(ITEM_START, x_i, y_i);
        while (drawing && steps < max_steps)
        begin
            send_request(ITEM_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));
            steps++;
        end
    endtask

    task automatic test_idle_step();
        send_request(ITEM_STEP, -12'sd2048, 12'sd2047);
        send_request(ITEM_STEP, 12'sd2047, -12'sd2048);
    endtask

    task automatic test_reset_axes();
        trace_ellipse(12'sd0, 12'sd0, 2);
    endtask

    task automatic test_unit_axes();
        set_axes(8'd1, 8'd1);
        trace_ellipse(12'sd2047, -12'sd2048, 1000);
        send_request(ITEM_STEP, 12'sd0, 12'sd0);
    endtask

    task automatic test_zero_axes();
        set_axes(8'd0, 8'd3);
        trace_ellipse(-12'sd2048, 12'sd2047, 1000);
        set_axes(8'd5, 8'd0);
        trace_ellipse(12'sd100, -12'sd100, 1000);
        send_request(ITEM_STEP, -12'sd1, -12'sd1);
    endtask

    task automatic test_axis_change_mid_ellipse();
        set_axes(8'd6, 8'd6);
        trace_ellipse(-12'sd2048, -12'sd2048, 3);
        set_axes(8'd8, 8'd4);
        while (drawing)
        begin
            send_request(ITEM_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
    endtask

    task automatic test_largest_axes();
        set_axes(8'd255, 8'd255);
        trace_ellipse(12'sd2047, 12'sd2047, 3);
        send_request(ITEM_START, -12'sd2048, -12'sd2048);
    endtask

    task automatic test_backpressure();
        set_axes(8'd30, 8'd18);
        no_gaps      = 1'b1;
        hold_pending = 1'b1;
        trace_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), 1000);
        no_gaps = 1'b0;
    endtask

    task automatic test_steady_stream();
        set_axes(8'd12, 8'd40);
        no_gaps = 1'b1;
        trace_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), 1000);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_ellipses();
        int  pick;
        int  a;
        int  b;
        int  max_steps;
        bit  wide;
        while (sent_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            wide = 1'b0;
            if (pick < 5)
            begin
                a    = $urandom_range(0, 1) ? 255 : $urandom_range(100, 255);
                b    = $urandom_range(0, 1) ? 255 : $urandom_range(100, 255);
                wide = 1'b1;
            end
            else if (pick < 15)
            begin
                a = $urandom_range(1, 80);
                b = $urandom_range(1, 80);
            end
            else
            begin
                a = $urandom_range(1, 24);
                b = $urandom_range(1, 24);
            end
            set_axes(AXIS_BITS'(a), AXIS_BITS'(b));
            repeat ($urandom_range(2, 4))
            begin
                pick = $urandom_range(0, 99);
                // noise: stray steps and lone starts
                if (pick < 10)
                begin
                    send_request(ITEM_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));
                end
                else if (pick < 18)
                begin
                    send_request(ITEM_START, COORD_BITS'($urandom), COORD_BITS'($urandom));
                end
                pick = $urandom_range(0, 99);
                if (wide)
                begin
                    max_steps = $urandom_range(4, 30);
                end
                else if (pick < 15)
                begin
                    max_steps = $urandom_range(1, 10);
                end
                else
                begin
                    max_steps = 1000;
                end
                trace_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), max_steps);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_step();
        test_reset_axes();
        test_unit_axes();
        test_zero_axes();
        test_axis_change_mid_ellipse();
        test_largest_axes();
        test_backpressure();
        test_steady_stream();
        test_random_ellipses();
        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
